// File: src/dpnr_pkg.sv
// Types and constants shared by the binary64 normalize-and-pack pipeline.
package dpnr_pkg;

   localparam int MANT_W     = 64;
   localparam int EXP_IN_W   = 16;
   localparam int LZ_W       = 6;
   localparam int EXP_W      = 18;
   localparam int SIG_W      = 53;
   localparam int FRAC_W     = 52;
   localparam int BEXP_W     = 11;
   localparam int SHIFT_W    = 6;

   localparam logic signed [EXP_W-1:0] EXP_BIAS       = 18'sd1023;
   localparam logic signed [EXP_W-1:0] EXP_MIN        = -18'sd1022;
   localparam logic signed [EXP_W-1:0] EXP_DENORM_MIN = -18'sd1074;
   localparam logic signed [EXP_W-1:0] NORM_OFFSET    = 18'sd11;
   localparam logic [BEXP_W-1:0]       EXP_ALL_ONES   = 11'h7ff;

   typedef struct packed {
      logic                       sign_in;
      logic signed [EXP_IN_W-1:0] exponent_in;
      logic [MANT_W-1:0]          mantissa_in;
   } req_type;

   typedef struct packed {
      logic [63:0] raw_bits;
      logic        is_infinite;
      logic        is_zero;
      logic        is_denormal;
   } rsp_type;

endpackage

// File: src/dpnr_lzc.sv
// Leading-zero count of a 64-bit word by a six-step binary search.
module dpnr_lzc
   import dpnr_pkg::*;
(
   input  logic [MANT_W-1:0] value,
   output logic [LZ_W-1:0]   count
);

   always_comb begin
      logic [MANT_W-1:0] x;
      x     = value;
      count = '0;
      for (int s = LZ_W - 1; s >= 0; s--) begin
         // test the top 2^s bits of what is left
         if ((x >> (MANT_W - (1 << s))) == '0) begin
            count[s] = 1'b1;
            x        = x << (1 << s);
         end
      end
   end

endmodule

// File: src/double_pack_normalize_round.sv
// Top level: four-stage pipeline that normalizes, rounds and packs a binary64.
//
//   channel   ports                        handshake
//   request   start, busy, req_data        taken when start is high and busy is low
//   response  rsp_strobe, rsp_data         one cycle per result, cannot be held off
//
// One transaction can enter every cycle. Stages: leading-zero count,
// normalizing shift, round-half-up add, then range check and denormal shift.
// busy stays low: the response side never stalls, so nothing backs up.
// Synchronous reset clears the stage valid bits only.
module double_pack_normalize_round
   import dpnr_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_strobe,
   output rsp_type rsp_data
);

   // stage 1: count leading zeros
   logic                    s1_valid_ff;
   logic                    s1_sign_ff;
   logic signed [EXP_IN_W-1:0] s1_exp_ff;
   logic [MANT_W-1:0]       s1_mant_ff;
   logic [LZ_W-1:0]         s1_lz_ff, s1_lz_in;
   logic                    s1_zero_ff;

   // stage 2: normalized word and adjusted exponent
   logic                    s2_valid_ff;
   logic                    s2_sign_ff;
   logic                    s2_zero_ff;
   logic [MANT_W-1:0]       s2_norm_ff, s2_norm_in;
   logic signed [EXP_W-1:0] s2_exp_ff, s2_exp_in;

   // stage 3: rounded 53-bit significand
   logic                    s3_valid_ff;
   logic                    s3_sign_ff;
   logic                    s3_zero_ff;
   logic [SIG_W-1:0]        s3_sig_ff, s3_sig_in;
   logic signed [EXP_W-1:0] s3_exp_ff, s3_exp_in;

   // stage 4: output register
   logic                    out_valid_ff;
   rsp_type                 out_data_ff, out_data_in;

   assign busy = 1'b0;

   dpnr_lzc u_lzc (
      .value (req_data.mantissa_in),
      .count (s1_lz_in)
   );

   always_comb begin
      logic [SIG_W:0] sum;
      s2_norm_in = s1_mant_ff << s1_lz_ff;
      s2_exp_in  = EXP_W'(s1_exp_ff) + NORM_OFFSET
                   - EXP_W'({{(EXP_W-LZ_W){1'b0}}, s1_lz_ff});
      sum        = {1'b0, s2_norm_ff[MANT_W-1 -: SIG_W]}
                   + {{SIG_W{1'b0}}, s2_norm_ff[MANT_W-1-SIG_W]};
      // a carry out of the add leaves one extra bit: shift right by one and bump the exponent
      if (sum[SIG_W]) begin
         s3_sig_in = sum[SIG_W:1];
         s3_exp_in = s2_exp_ff + EXP_W'(1);
      end else begin
         s3_sig_in = sum[SIG_W-1:0];
         s3_exp_in = s2_exp_ff;
      end
   end

   always_comb begin
      logic [SHIFT_W-1:0] sh;
      logic [EXP_W-1:0]   diff;
      logic [EXP_W-1:0]   biased;
      diff        = EXP_MIN - s3_exp_ff;
      sh          = diff[SHIFT_W-1:0];
      biased      = s3_exp_ff + EXP_BIAS;
      out_data_in = '0;
      priority if (s3_zero_ff) begin
         out_data_in.is_zero = 1'b1;
      end else if (s3_exp_ff > EXP_BIAS) begin
         out_data_in.raw_bits    = {s3_sign_ff, EXP_ALL_ONES, {FRAC_W{1'b0}}};
         out_data_in.is_infinite = 1'b1;
      end else if (s3_exp_ff < EXP_DENORM_MIN) begin
         out_data_in.is_zero = 1'b1;
      end else if (s3_exp_ff < EXP_MIN) begin
         // truncate into the denormal encoding, no second rounding
         out_data_in.raw_bits    = {s3_sign_ff, {BEXP_W{1'b0}},
                                    FRAC_W'(s3_sig_ff >> sh)};
         out_data_in.is_denormal = 1'b1;
      end else begin
         out_data_in.raw_bits = {s3_sign_ff, biased[BEXP_W-1:0], s3_sig_ff[FRAC_W-1:0]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= start && !busy;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         out_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_sign_ff  <= req_data.sign_in;
      s1_exp_ff   <= req_data.exponent_in;
      s1_mant_ff  <= req_data.mantissa_in;
      s1_lz_ff    <= s1_lz_in;
      s1_zero_ff  <= (req_data.mantissa_in == '0);

      s2_sign_ff  <= s1_sign_ff;
      s2_zero_ff  <= s1_zero_ff;
      s2_norm_ff  <= s2_norm_in;
      s2_exp_ff   <= s2_exp_in;

      s3_sign_ff  <= s2_sign_ff;
      s3_zero_ff  <= s2_zero_ff;
      s3_sig_ff   <= s3_sig_in;
      s3_exp_ff   <= s3_exp_in;

      out_data_ff <= out_data_in;
   end

   assign rsp_strobe = out_valid_ff;
   assign rsp_data   = out_data_ff;

endmodule

// File: sim/tb.sv
// Testbench for double_pack_normalize_round: random and corner-case packing checked by a scoreboard.
`timescale 1ns / 1ps

module tb;
   import dpnr_pkg::*;

   localparam logic [63:0] FRAC_MASK   = 64'h000F_FFFF_FFFF_FFFF;
   localparam int          RANDOM_REQS = 850;

   class pack_scoreboard;
      rsp_type     expected_packs[$];
      req_type     source_reqs[$];
      int unsigned mismatches;
      int unsigned orphans;

      function new();
         mismatches = 0;
         orphans    = 0;
      endfunction

      function int pending();
         return expected_packs.size();
      endfunction

      // Normalize to 53 bits, round half up, then range-check and pack.
      function rsp_type pack_binary64(req_type r);
         rsp_type     res;
         logic [63:0] m;
         logic [10:0] bexp;
         logic        rnd;
         int          e;
         int          adj;
         int          blen;
         int          sh;
         int          i;
         res  = '0;
         m    = r.mantissa_in;
         blen = 0;
         if (m == 64'h0) begin
            res.is_zero = 1'b1;
            return res;
         end
         e = int'($signed(r.exponent_in));
         for (i = 0; i < 64; i++) begin
            if (m[i]) blen = i + 1;
         end
         adj = blen - SIG_W;
         if (adj > 0) begin
            m   = m >> (adj - 1);
            rnd = m[0];
            m   = m >> 1;
            m   = m + 64'(rnd);
            // carry out of rounding: renormalize
            if (m[SIG_W]) begin
               m   = m >> 1;
               adj = adj + 1;
            end
         end else if (adj < 0) begin
            m = m << (-adj);
         end
         e = e + adj;
         if (e > int'(EXP_BIAS)) begin
            res.raw_bits    = {r.sign_in, EXP_ALL_ONES, 52'h0};
            res.is_infinite = 1'b1;
         end else if (e < int'(EXP_DENORM_MIN)) begin
            res.is_zero = 1'b1;
         end else if (e < int'(EXP_MIN)) begin
            sh              = int'(EXP_MIN) - e;
            res.raw_bits    = {r.sign_in, 63'h0} | ((m >> sh) & FRAC_MASK);
            res.is_denormal = 1'b1;
         end else begin
            bexp         = 11'(e + int'(EXP_BIAS));
            res.raw_bits = {r.sign_in, bexp, m[FRAC_W-1:0]};
         end
         return res;
      endfunction

      function void note_request(req_type r);
         expected_packs.push_back(pack_binary64(r));
         source_reqs.push_back(r);
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         req_type src;
         if (expected_packs.size() == 0) begin
            orphans++;
            if (orphans + mismatches <= 10)
               $display("unexpected result: raw=%h inf=%b zero=%b den=%b",
                        got.raw_bits, got.is_infinite, got.is_zero, got.is_denormal);
            return;
         end
         want = expected_packs.pop_front();
         src  = source_reqs.pop_front();
         if (got.raw_bits !== want.raw_bits || got.is_infinite !== want.is_infinite ||
             got.is_zero !== want.is_zero || got.is_denormal !== want.is_denormal) begin
            mismatches++;
            if (orphans + mismatches <= 10) begin
               $display("mismatch: in sign=%b exp=%0d mant=%h", src.sign_in,
                        $signed(src.exponent_in), src.mantissa_in);
               $display("   want raw=%h inf=%b zero=%b den=%b", want.raw_bits,
                        want.is_infinite, want.is_zero, want.is_denormal);
               $display("   got  raw=%h inf=%b zero=%b den=%b", got.raw_bits,
                        got.is_infinite, got.is_zero, got.is_denormal);
            end
         end
      endfunction
   endclass

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_strobe;
   rsp_type rsp_data;

   pack_scoreboard sb = new();

   double_pack_normalize_round u_top (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function req_type make_request(bit s, int e, logic [63:0] m);
      req_type r;
      r.sign_in     = s;
      r.exponent_in = 16'(e);
      r.mantissa_in = m;
      return r;
   endfunction

   function req_type random_request();
      logic [63:0] m;
      int          pick;
      int          base;
      int          e;
      pick = $urandom_range(0, 99);
      if (pick < 5)
         m = 64'h0;
      else if (pick < 20)
         m = {$urandom, $urandom};
      else if (pick < 35)
         m = ~64'h0 >> $urandom_range(0, 10);   // runs of ones force a rounding carry
      else if (pick < 45)
         m = {1'b1, 20'($urandom), 32'($urandom), 11'h400};   // exact halfway
      else
         m = {$urandom, $urandom} >> $urandom_range(0, 63);
      if ($urandom_range(0, 99) < 20) begin
         e = int'($signed(16'($urandom)));
      end else begin
         case ($urandom_range(0, 3))
            0: base = int'(EXP_BIAS);
            1: base = int'(EXP_MIN);
            2: base = int'(EXP_DENORM_MIN);
            default: base = 0;
         endcase
         e = base + int'($urandom_range(0, 140)) - 70;
      end
      return make_request(1'($urandom_range(0, 1)), e, m);
   endfunction

   // Hold start until the transaction is taken, idling first now and then.
   task automatic send_request(input req_type r, input bit may_idle);
      if (may_idle) begin
         while ($urandom_range(0, 99) < 8) begin
            @(negedge clock);
            start    <= 1'b0;
            req_data <= random_request();
         end
      end
      @(negedge clock);
      start    <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy);
      sb.note_request(r);
   endtask

   task automatic drain_results();
      @(negedge clock);
      start <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_strobe === 1'b1) sb.check_result(rsp_data);
   end

   initial begin
      int n;
      start    = 1'b0;
      req_data = '0;
      reset    = 1'b1;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // zero mantissa, either sign
      send_request(make_request(1, 0, 64'h0), 0);
      send_request(make_request(0, 32767, 64'h0), 1);
      // short, exact and long mantissas
      send_request(make_request(0, 0, 64'h1), 1);
      send_request(make_request(1, 0, 64'h0010_0000_0000_0000), 0);
      send_request(make_request(0, 0, 64'h001F_FFFF_FFFF_FFFF), 1);
      send_request(make_request(0, 0, 64'h003F_FFFF_FFFF_FFFF), 0);
      send_request(make_request(1, 0, 64'hFFFF_FFFF_FFFF_FFFF), 1);
      send_request(make_request(0, 0, 64'h0020_0000_0000_0001), 0);
      send_request(make_request(0, 5, 64'h8000_0000_0000_0400), 0);
      send_request(make_request(1, 5, 64'h8000_0000_0000_03FF), 1);
      // top of the range and overflow
      send_request(make_request(0, 1023, 64'h0010_0000_0000_0000), 0);
      send_request(make_request(1, 1024, 64'h0010_0000_0000_0000), 0);
      send_request(make_request(0, 1023, 64'hFFFF_FFFF_FFFF_FFFF), 1);
      send_request(make_request(1, 1075, 64'h1), 0);
      send_request(make_request(0, 1076, 64'h1), 0);
      send_request(make_request(1, 32767, 64'h1), 1);
      // bottom of the range, denormals and deep underflow
      send_request(make_request(0, -1022, 64'h0010_0000_0000_0000), 0);
      send_request(make_request(1, -1023, 64'h001F_FFFF_FFFF_FFFF), 0);
      send_request(make_request(0, -1074, 64'h0010_0000_0000_0000), 1);
      send_request(make_request(1, -1075, 64'h0010_0000_0000_0000), 0);
      send_request(make_request(1, -1022, 64'h1), 0);
      send_request(make_request(0, -1023, 64'h1), 0);
      send_request(make_request(1, -32768, 64'hFFFF_FFFF_FFFF_FFFF), 1);
      send_request(make_request(0, -32768, 64'h1), 0);
      drain_results();

      for (n = 0; n < RANDOM_REQS; n++) begin
         send_request(random_request(), !(n >= 300 && n < 550));
         if (n == 600) drain_results();
      end
      drain_results();

      if (sb.mismatches == 0 && sb.orphans == 0 && sb.pending() == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end

   initial begin
      #500000;
      $display("tb: done, errors");
      $finish;
   end

endmodule
